>>> src/sba_pkg.sv
package sba_pkg;

    localparam int MAG_W      = 15;
    localparam int LIMIT_W    = 10;
    localparam int SUM_W      = 25;
    localparam int BAND_W     = 4;
    localparam int BAND_NUM_W = 3;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    localparam int NUM_BANDS_DEF = 8;
    localparam int MAX_BINS_DEF  = 1024;

    typedef logic [LIMIT_W-1:0] limit_t;

    localparam limit_t LIMIT_RESET [NUM_REGS] = '{
        limit_t'(1), limit_t'(3), limit_t'(7), limit_t'(15),
        limit_t'(31), limit_t'(63), limit_t'(127), limit_t'(255)
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_LOAD,
        ST_SEND,
        ST_FINISH
    } sba_state_t;

endpackage

>>> src/spectrum_band_averager_core.sv
// channel | direction | handshake          | payload
// --------+-----------+--------------------+---------------------------------------
// in      | input     | in_valid/in_ready  | magnitude, frame_end
// out     | output    | out_valid/out_ready| band_level, band_number, last_of_run
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A bin that closes no band goes through ST_CHECK and ST_FINISH before in_ready
// returns. Each band that closes goes through ST_CHECK, ST_LOAD and ST_SEND and
// waits in ST_SEND on out_ready; a band with bins also runs the shared restoring
// divider in ST_DIV (one quotient bit per cycle) before ST_LOAD.
// Reset clears the bin counter, band index, band start and sum, and loads the
// default band limits. in_ready is low while a bin is in flight; a stalled
// output word holds the sequencer in place.
module spectrum_band_averager_core #(
    parameter int NUM_BANDS = sba_pkg::NUM_BANDS_DEF,
    parameter int MAX_BINS  = sba_pkg::MAX_BINS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sba_pkg::MAG_W-1:0]        magnitude,
    input  logic                             frame_end,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sba_pkg::MAG_W-1:0]        band_level,
    output logic [sba_pkg::BAND_NUM_W-1:0]   band_number,
    output logic                             last_of_run,
    input  logic                             cfg_we,
    input  logic [sba_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [sba_pkg::LIMIT_W-1:0]      cfg_data
);

    localparam int CW   = $clog2(MAX_BINS);
    localparam int CMPW = (CW > sba_pkg::LIMIT_W) ? CW : sba_pkg::LIMIT_W;

    sba_pkg::sba_state_t state_reg, state_next;

    sba_pkg::limit_t limit_reg [sba_pkg::NUM_REGS];

    logic [CW-1:0]                   bin_reg, bin_next;
    logic [sba_pkg::BAND_W-1:0]      band_reg, band_next;
    logic [CW-1:0]                   start_reg, start_next;
    logic [sba_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic                            end_reg, end_next;
    logic                            out_valid_reg, out_valid_next;

    logic [sba_pkg::MAG_W-1:0]       level_reg, level_next;
    logic [sba_pkg::BAND_NUM_W-1:0]  num_reg, num_next;
    logic                            last_reg, last_next;
    logic [sba_pkg::SUM_W-1:0]       quo_reg, quo_next;
    logic [CW:0]                     rem_reg, rem_next;
    logic [CW:0]                     den_reg, den_next;
    logic [sba_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    sba_pkg::limit_t                 lim_sel;
    logic                            band_active;
    logic                            band_empty;
    logic                            band_hit;
    logic                            band_closes;
    logic [CW+1:0]                   trial;
    logic                            trial_ge;

    assign lim_sel     = limit_reg[band_reg[sba_pkg::REG_IDX_W-1:0]];
    assign band_active = band_reg < sba_pkg::BAND_W'(NUM_BANDS);
    assign band_empty  = CMPW'(lim_sel) < CMPW'(start_reg);
    assign band_hit    = CMPW'(lim_sel) <= CMPW'(bin_reg);
    assign band_closes = band_active && (band_empty || band_hit);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial    = {rem_reg, quo_reg[sba_pkg::SUM_W-1]};
    assign trial_ge = trial >= {1'b0, den_reg};

    assign in_ready    = state_reg == sba_pkg::ST_IDLE;
    assign out_valid   = out_valid_reg;
    assign band_level  = level_reg;
    assign band_number = num_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        band_next      = band_reg;
        start_next     = start_reg;
        sum_next       = sum_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        num_next       = num_reg;
        last_next      = last_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;

        case (state_reg)
            sba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    end_next = frame_end;
                    if (band_active)
                    begin
                        sum_next = sum_reg + sba_pkg::SUM_W'(magnitude);
                    end
                    state_next = sba_pkg::ST_CHECK;
                end
            end
            sba_pkg::ST_CHECK:
            begin
                num_next = band_reg[sba_pkg::BAND_NUM_W-1:0];
                if (!band_closes)
                begin
                    state_next = sba_pkg::ST_FINISH;
                end
                else if (band_empty)
                begin
                    // empty band: report zero, keep band start
                    level_next = '0;
                    band_next  = band_reg + 1'b1;
                    state_next = sba_pkg::ST_LOAD;
                end
                else
                begin
                    den_next   = (CW+1)'(bin_reg) - (CW+1)'(start_reg) + 1'b1;
                    quo_next   = sum_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = sba_pkg::ST_DIV;
                end
            end
            sba_pkg::ST_DIV:
            begin
                if (trial_ge)
                begin
                    rem_next = (CW+1)'(trial - {1'b0, den_reg});
                end
                else
                begin
                    rem_next = trial[CW:0];
                end
                quo_next = {quo_reg[sba_pkg::SUM_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == sba_pkg::DIV_CNT_W'(sba_pkg::SUM_W - 1))
                begin
                    level_next = quo_next[sba_pkg::MAG_W-1:0];
                    sum_next   = '0;
                    start_next = bin_reg + 1'b1;
                    band_next  = band_reg + 1'b1;
                    state_next = sba_pkg::ST_LOAD;
                end
            end
            sba_pkg::ST_LOAD:
            begin
                // look ahead at the next band to flag the final word
                last_next      = !band_closes;
                out_valid_next = 1'b1;
                state_next     = sba_pkg::ST_SEND;
            end
            sba_pkg::ST_SEND:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = last_reg ? sba_pkg::ST_FINISH : sba_pkg::ST_CHECK;
                end
            end
            sba_pkg::ST_FINISH:
            begin
                if (end_reg || (bin_reg >= CW'(MAX_BINS - 1)))
                begin
                    bin_next   = '0;
                    band_next  = '0;
                    start_next = '0;
                    sum_next   = '0;
                end
                else
                begin
                    bin_next = bin_reg + 1'b1;
                end
                state_next = sba_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sba_pkg::ST_IDLE;
            bin_reg       <= '0;
            band_reg      <= '0;
            start_reg     <= '0;
            sum_reg       <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < sba_pkg::NUM_REGS; i++)
            begin
                limit_reg[i] <= sba_pkg::LIMIT_RESET[i];
            end
        end
        else
        begin
            state_reg     <= state_next;
            bin_reg       <= bin_next;
            band_reg      <= band_next;
            start_reg     <= start_next;
            sum_reg       <= sum_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        num_reg   <= num_next;
        last_reg  <= last_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        cnt_reg   <= cnt_next;
    end

endmodule

>>> src/sba_checker.sv
module sba_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [sba_pkg::MAG_W-1:0]        band_level,
    input logic [sba_pkg::BAND_NUM_W-1:0]   band_number,
    input logic                             last_of_run
);

    // a pending word holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(band_level)
            && $stable(band_number) && $stable(last_of_run))
        else $error("output word changed while stalled");

    // one bin at a time: no new bin while a word is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accepting a bin");

    // more words of this bin follow, so input stays closed
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> !in_ready)
        else $error("input reopened before the final word of a run");

endmodule

bind spectrum_band_averager_core sba_checker u_sba_checker (.*);

>>> verif/spectrum_band_averager_core_tb.sv
module spectrum_band_averager_core_tb;

    import sba_pkg::*;

    localparam int BANDS          = NUM_BANDS_DEF;
    localparam int BINS           = MAX_BINS_DEF;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int END_CYCLES     = 250;
    localparam int MAX_PRINTS     = 100;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LIMIT0,
        REG_LIMIT1,
        REG_LIMIT2,
        REG_LIMIT3,
        REG_LIMIT4,
        REG_LIMIT5,
        REG_LIMIT6,
        REG_LIMIT7
    } limit_reg_e;

    typedef struct packed {
        logic [MAG_W-1:0]      level;
        logic [BAND_NUM_W-1:0] band;
        logic                  last;
    } band_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [MAG_W-1:0]      magnitude = '0;
    logic                  frame_end = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [MAG_W-1:0]      band_level;
    logic [BAND_NUM_W-1:0] band_number;
    logic                  last_of_run;
    logic                  cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [LIMIT_W-1:0]    cfg_data = '0;

    // band averaging state as the testbench sees it
    limit_t           band_limits [NUM_REGS] = LIMIT_RESET;
    limit_t           limit_plan [NUM_REGS];
    logic [LIMIT_W-1:0] bin_index = '0;
    logic [BAND_W-1:0]  open_band = '0;
    logic [LIMIT_W:0]   band_first_bin = '0;
    logic [SUM_W-1:0]   band_total = '0;

    band_word_t band_words_q [$];
    int         live_bins = 0;
    int         mismatches = 0;
    logic       idle_on = 1'b1;
    logic       rx_blocked = 1'b0;
    int         rx_gap = 0;
    event       hold_output_ev;

    spectrum_band_averager_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .magnitude  (magnitude),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .band_level (band_level),
        .band_number(band_number),
        .last_of_run(last_of_run),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Close every band whose limit this bin reaches and queue its level.
    function automatic void average_bands(input logic [MAG_W-1:0] mag, input logic last_bin);
        logic [LIMIT_W-1:0] bin;
        limit_t             lim;
        logic [LIMIT_W:0]   count;
        logic [SUM_W-1:0]   quotient;
        band_word_t         pending;
        logic               have_pending;
        logic               closing;
        bin = bin_index;
        have_pending = 1'b0;
        pending = '0;
        live_bins++;
        if (open_band < BANDS)
        begin
            band_total = band_total + SUM_W'(mag);
            closing = 1'b1;
            while (closing && open_band < BANDS)
            begin
                lim = band_limits[open_band[BAND_NUM_W-1:0]];
                if ({1'b0, lim} < band_first_bin)
                begin
                    quotient = '0;
                end
                else if (lim <= bin)
                begin
                    count = {1'b0, bin} - band_first_bin + 1'b1;
                    quotient = band_total / SUM_W'(count);
                    band_total = '0;
                    band_first_bin = {1'b0, bin} + 1'b1;
                end
                else
                begin
                    closing = 1'b0;
                end
                if (closing)
                begin
                    if (have_pending)
                        band_words_q.push_back(pending);
                    pending.level = quotient[MAG_W-1:0];
                    pending.band = open_band[BAND_NUM_W-1:0];
                    pending.last = 1'b0;
                    have_pending = 1'b1;
                    open_band++;
                end
            end
            if (have_pending)
            begin
                pending.last = 1'b1;
                band_words_q.push_back(pending);
            end
        end
        if (last_bin || bin == LIMIT_W'(BINS - 1))
        begin
            bin_index = '0;
            open_band = '0;
            band_first_bin = '0;
            band_total = '0;
        end
        else
        begin
            bin_index = bin + 1'b1;
        end
    endfunction

    function automatic logic [MAG_W-1:0] random_mag();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return MAG_W'($urandom_range(0, 32767));
        endcase
    endfunction

    // Leave valid high after acceptance; the next call or a drain decides.
    task automatic send_bin(input logic [MAG_W-1:0] mag, input logic last_bin);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        magnitude <= mag;
        frame_end <= last_bin;
        do
            @(posedge clk);
        while (!in_ready);
        average_bands(mag, last_bin);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (band_words_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input limit_reg_e idx, input limit_t value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        band_limits[idx] = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_limits();
        int i;
        wait_drained();
        for (i = 0; i < NUM_REGS; i++)
            write_limit(limit_reg_e'(i), limit_plan[i]);
    endtask

    function automatic int plan_random_limits();
        int acc;
        int span;
        int pick;
        int i;
        acc = 0;
        span = 0;
        pick = $urandom_range(0, 3);
        for (i = 0; i < NUM_REGS; i++)
        begin
            case (pick)
                0, 1:
                begin
                    acc += $urandom_range(0, 5);
                    limit_plan[i] = limit_t'(acc);
                end
                2: limit_plan[i] = limit_t'($urandom_range(0, 40));
                default: limit_plan[i] = ($urandom_range(0, 2) == 0) ? '1
                                         : limit_t'($urandom_range(0, 20));
            endcase
            if (limit_plan[i] < 50 && int'(limit_plan[i]) > span)
                span = int'(limit_plan[i]);
        end
        return span;
    endfunction

    // defaults after reset; the frame ends inside band three
    task automatic test_reset_limits();
        int bin;
        for (bin = 0; bin < 9; bin++)
            send_bin(bin < 2 ? '1 : (bin == 2 ? '0 : random_mag()), bin == 8);
        wait_drained();
    endtask

    // zero and full-scale limits, with empty bands between them
    task automatic test_limit_extremes();
        int bin;
        limit_plan = '{10'd0, 10'd0, 10'd2, 10'd2, 10'd5, 10'h3FF, 10'h3FF, 10'h3FF};
        program_limits();
        for (bin = 0; bin < 7; bin++)
            send_bin(random_mag(), bin == 6);
        wait_drained();
    endtask

    // one bin closes all eight bands; later bins are dropped
    task automatic test_one_step_closes_all();
        int bin;
        limit_plan = '{default: 10'd3};
        program_limits();
        for (bin = 0; bin < 7; bin++)
            send_bin(random_mag(), bin == 6);
        for (bin = 0; bin < 4; bin++)
            send_bin(random_mag(), bin == 3);
        wait_drained();
    endtask

    // lower a limit mid-frame below the current bin
    task automatic test_limit_passed();
        int bin;
        limit_plan = '{10'd1, 10'd200, 10'd2, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF};
        program_limits();
        for (bin = 0; bin < 6; bin++)
            send_bin(random_mag(), 1'b0);
        wait_drained();
        write_limit(REG_LIMIT1, 10'd3);
        send_bin(random_mag(), 1'b0);
        send_bin(random_mag(), 1'b1);
        wait_drained();
    endtask

    // hold the output while bins are offered, then drain
    task automatic test_output_backpressure();
        int bin;
        limit_plan = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7};
        program_limits();
        -> hold_output_ev;
        for (bin = 0; bin < 12; bin++)
            send_bin(random_mag(), bin == 11);
        wait_drained();
    endtask

    task automatic test_random_frames(input int bin_goal);
        int start_bins;
        int span;
        int frames;
        int frame_len;
        int f;
        int pos;
        start_bins = live_bins;
        while (live_bins - start_bins < bin_goal)
        begin
            span = plan_random_limits();
            program_limits();
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++)
            begin
                frame_len = $urandom_range(1, span + 6);
                for (pos = 0; pos < frame_len; pos++)
                begin
                    if ($urandom_range(0, 39) == 0)
                    begin
                        wait_drained();
                        write_limit(limit_reg_e'($urandom_range(0, NUM_REGS - 1)),
                                    limit_t'($urandom_range(0, 48)));
                    end
                    send_bin(random_mag(),
                             (pos == frame_len - 1) || ($urandom_range(0, 59) == 0));
                end
            end
        end
    endtask

    always
    begin
        @(hold_output_ev);
        rx_blocked <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_blocked <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rx_blocked)
        begin
            out_ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            out_ready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            rx_gap <= $urandom_range(0, 2);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_words
        band_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (band_words_q.size() == 0)
            begin
                report_mismatch("unexpected word for band", int'(band_number), -1);
            end
            else
            begin
                want = band_words_q.pop_front();
                if (band_level !== want.level)
                    report_mismatch("band_level", int'(band_level), int'(want.level));
                if (band_number !== want.band)
                    report_mismatch("band_number", int'(band_number), int'(want.band));
                if (last_of_run !== want.last)
                    report_mismatch("last_of_run", int'(last_of_run), int'(want.last));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("spectrum_band_averager_core_tb: FAIL");
        $finish;
    end

    initial
    begin : run_tests
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_limits();
        test_limit_extremes();
        test_one_step_closes_all();
        test_limit_passed();
        test_output_backpressure();
        test_random_frames(150);
        // finish with no idling on either side
        idle_on <= 1'b0;
        test_random_frames(30);
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (band_words_q.size() != 0)
            report_mismatch("words still expected", band_words_q.size(), 0);
        if (mismatches == 0)
            $display("spectrum_band_averager_core_tb: PASS");
        else
            $display("spectrum_band_averager_core_tb: FAIL");
        $finish;
    end

endmodule
